// ===== rtl/mmcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcp_pkg
// Shared sizes, types and state codes of the min-max contiguous partition unit.
// ----------------------------------------------------------------------------
package mmcp_pkg;

    localparam int MAX_ITEMS   = 256;
    localparam int WEIGHT_BITS = 16;

    localparam int WEIGHT_W = 16;
    localparam int LIMIT_W  = 9;
    localparam int TOTAL_W  = 24;
    localparam int SUM_W    = TOTAL_W + 1;
    localparam int ADDR_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int GC_W     = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MID,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } mmcp_state_t;

endpackage

// ===== rtl/mmcp_ram.sv =====
// ----------------------------------------------------------------------------
// mmcp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mmcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/min_max_contiguous_partition_unit.sv =====
// ----------------------------------------------------------------------------
// min_max_contiguous_partition_unit
// Smallest largest-group sum of a weight sequence split into contiguous groups.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one weight per transaction, s_last closes the set.
//   Weights are stored in a RAM in arrival order; items beyond MAX_ITEMS are
//   dropped, not summed, and reported through m_overflowed.
//   Configuration channel cfg_*: writes group_limit; always ready, write only
//   while the block is idle.
//   Output channel m_*: one transaction per set, holding min_max_load.
// Search:
//   Non-last weights are accepted back to back. After the last weight the block
//   runs a binary search over [0, total]: up to R = ceil(log2(total + 2))
//   rounds, at most 25, each a greedy scan of the stored weights through the
//   single RAM read port; s_ready stays low during the search.
// Reset: group_limit returns to 1, the set is empty, no result is pending.
// Stall: the result waits in the output register while the next set loads and
//   is searched; that set's result is held until the register is free, and
//   s_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module min_max_contiguous_partition_unit
    import mmcp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_group_limit,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TOTAL_W-1:0]  m_min_max_load,
    output logic                m_overflowed
);

    mmcp_state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0]   item_cnt_reg, item_cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic [SUM_W-1:0]   low_reg, low_next;
    logic [SUM_W-1:0]   hx_reg, hx_next;
    logic [TOTAL_W-1:0] mid_reg, mid_next;
    logic [TOTAL_W-1:0] best_reg, best_next;
    logic [TOTAL_W-1:0] gsum_reg, gsum_next;
    logic [CNT_W-1:0]   gcount_reg, gcount_next;
    logic               fail_reg, fail_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   proc_cnt_reg, proc_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] m_load_reg, m_load_next;
    logic               m_ovf_reg, m_ovf_next;

    logic                   s_take;
    logic                   wr_en;
    logic                   rd_en;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic [SUM_W-1:0]       add_total;
    logic [SUM_W-1:0]       mid_sum;
    logic [SUM_W-1:0]       w_ext;
    logic [SUM_W-1:0]       sum_try;
    logic [SUM_W-1:0]       bound_ext;
    logic [GC_W-1:0]        gcount_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign s_take    = s_valid && s_ready;
    assign wr_data   = s_weight[WEIGHT_BITS-1:0];
    assign wr_en     = s_take && (item_cnt_reg < CNT_W'(MAX_ITEMS));
    assign rd_en     = (state_reg == ST_SCAN) && (rd_idx_reg < item_cnt_reg);

    assign add_total  = SUM_W'(total_reg) + SUM_W'(wr_data);
    assign mid_sum    = low_reg + hx_reg - SUM_W'(1);
    assign w_ext      = SUM_W'(rd_data);
    assign sum_try    = SUM_W'(gsum_reg) + w_ext;
    assign bound_ext  = SUM_W'(mid_reg);
    assign gcount_inc = GC_W'(gcount_reg) + GC_W'(1);

    mmcp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_weight_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (item_cnt_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            limit_reg    <= LIMIT_RESET;
            item_cnt_reg <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            item_cnt_reg <= item_cnt_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            rd_vld_reg   <= rd_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg      <= low_next;
        hx_reg       <= hx_next;
        mid_reg      <= mid_next;
        best_reg     <= best_next;
        gsum_reg     <= gsum_next;
        gcount_reg   <= gcount_next;
        fail_reg     <= fail_next;
        rd_idx_reg   <= rd_idx_next;
        proc_cnt_reg <= proc_cnt_next;
        m_load_reg   <= m_load_next;
        m_ovf_reg    <= m_ovf_next;
    end

    always_comb begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        item_cnt_next = item_cnt_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        low_next      = low_reg;
        hx_next       = hx_reg;
        mid_next      = mid_reg;
        best_next     = best_reg;
        gsum_next     = gsum_reg;
        gcount_next   = gcount_reg;
        fail_next     = fail_reg;
        rd_idx_next   = rd_idx_reg;
        proc_cnt_next = proc_cnt_reg;
        rd_vld_next   = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_load_next   = m_load_reg;
        m_ovf_next    = m_ovf_reg;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_group_limit;
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_take) begin
                    if (wr_en) begin
                        item_cnt_next = item_cnt_reg + CNT_W'(1);
                        total_next    = (add_total > SUM_W'(TOTAL_MAX)) ?
                                        TOTAL_MAX : add_total[TOTAL_W-1:0];
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        low_next   = '0;
                        hx_next    = (wr_en ? SUM_W'(total_next) : SUM_W'(total_reg))
                                     + SUM_W'(1);
                        best_next  = TOTAL_MAX;
                        state_next = ST_MID;
                    end
                end
            end
            ST_MID: begin
                if (low_reg < hx_reg) begin
                    mid_next      = mid_sum[SUM_W-1:1];
                    gsum_next     = '0;
                    gcount_next   = CNT_W'(1);
                    fail_next     = 1'b0;
                    rd_idx_next   = '0;
                    proc_cnt_next = '0;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    proc_cnt_next = proc_cnt_reg + CNT_W'(1);
                    if (sum_try <= bound_ext) begin
                        gsum_next = sum_try[TOTAL_W-1:0];
                    end else if (gcount_inc > GC_W'(limit_reg) || w_ext > bound_ext) begin
                        fail_next = 1'b1;
                    end else begin
                        gcount_next = gcount_inc[CNT_W-1:0];
                        gsum_next   = w_ext[TOTAL_W-1:0];
                    end
                    if (fail_next || proc_cnt_next == item_cnt_reg) begin
                        rd_vld_next = 1'b0;
                        state_next  = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (fail_reg) begin
                    low_next = SUM_W'(mid_reg) + SUM_W'(1);
                end else begin
                    best_next = mid_reg;
                    hx_next   = SUM_W'(mid_reg);
                end
                state_next = ST_MID;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_load_next   = best_reg;
                    m_ovf_next    = ovf_reg;
                    item_cnt_next = '0;
                    total_next    = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_min_max_load = m_load_reg;
    assign m_overflowed   = m_ovf_reg;

    a_set_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MID || state_reg == ST_SCAN || state_reg == ST_DECIDE)
        |-> item_cnt_reg != '0)
        else $error("search running on an empty set");

    a_groups_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> gcount_reg <= item_cnt_reg)
        else $error("group count exceeds stored item count");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (SUM_W'(mid_reg) >= low_reg && SUM_W'(mid_reg) < hx_reg))
        else $error("probe bound outside search interval");

    a_drop_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && item_cnt_reg == CNT_W'(MAX_ITEMS)) |=> ovf_reg)
        else $error("dropped transaction not flagged");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-max contiguous partition unit. Weight sets
// are streamed in over valid/ready with random gaps. A software partition
// search predicts the smallest feasible largest group sum and the drop flag
// of every set. Results are compared in order under random output stalls.
// ----------------------------------------------------------------------------
module tb_top
    import mmcp_pkg::*;
();

    localparam int     HALF_PERIOD   = 4;
    localparam int     RESET_CYCLES  = 7;
    localparam int     RANDOM_ITEMS  = 700;
    localparam int     PHASE_ITEMS   = 120;
    localparam int     HOLD_CYCLES   = 3000;
    localparam int     SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT   = 1500000;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = WEIGHT_W'((64'd1 << WEIGHT_BITS) - 1);

    typedef struct {
        logic [TOTAL_W-1:0] load;
        logic               overflowed;
    } partition_result_t;

    class partition_checker;
        logic [LIMIT_W-1:0]  group_limit;
        logic [WEIGHT_W-1:0] set_weights[$];
        longint unsigned     set_total;
        bit                  set_dropped;
        partition_result_t   expected_loads[$];
        int                  errors;

        function new();
            group_limit = LIMIT_RESET;
            set_total   = 0;
            set_dropped = 0;
            errors      = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            group_limit = value;
        endfunction

        function int pending();
            return expected_loads.size();
        endfunction

        function bit bound_fits(longint unsigned bound);
            longint unsigned group_sum;
            int unsigned     groups;
            groups    = 1;
            group_sum = 0;
            foreach (set_weights[i]) begin
                if (group_sum + set_weights[i] <= bound) begin
                    group_sum += set_weights[i];
                end else begin
                    groups++;
                    if (groups > group_limit || set_weights[i] > bound)
                        return 0;
                    group_sum = set_weights[i];
                end
            end
            return 1;
        endfunction

        function longint unsigned min_max_bound();
            longint          lo;
            longint          hi;
            longint          mid;
            longint unsigned best;
            lo   = 0;
            hi   = longint'(set_total);
            best = TOTAL_MAX;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (bound_fits(longint'(mid))) begin
                    best = mid;
                    hi   = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            return best;
        endfunction

        function void note_weight(logic [WEIGHT_W-1:0] weight, logic last);
            partition_result_t r;
            if (set_weights.size() < MAX_ITEMS) begin
                set_weights.push_back(weight & WEIGHT_MASK);
                set_total += weight & WEIGHT_MASK;
                if (set_total > TOTAL_MAX)
                    set_total = TOTAL_MAX;
            end else begin
                set_dropped = 1;
            end
            if (last) begin
                r.load       = TOTAL_W'(min_max_bound());
                r.overflowed = set_dropped;
                expected_loads.push_back(r);
                set_weights.delete();
                set_total   = 0;
                set_dropped = 0;
            end
        endfunction

        function void check_load(logic [TOTAL_W-1:0] load, logic overflowed);
            partition_result_t want;
            if (expected_loads.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual load %0d overflowed %0b",
                         $time, load, overflowed);
                return;
            end
            want = expected_loads.pop_front();
            if (load !== want.load) begin
                errors++;
                $display("%0t: min_max_load mismatch: expected %0d, actual %0d",
                         $time, want.load, load);
            end
            if (overflowed !== want.overflowed) begin
                errors++;
                $display("%0t: overflowed mismatch: expected %0b, actual %0b",
                         $time, want.overflowed, overflowed);
            end
        endfunction

        function void report_leftover();
            if (expected_loads.size() != 0) begin
                errors += expected_loads.size();
                $display("%0t: missing results: expected %0d more, actual 0",
                         $time, expected_loads.size());
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_group_limit;
    logic                s_valid;
    logic                s_ready;
    logic [WEIGHT_W-1:0] s_weight;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    logic [TOTAL_W-1:0]  m_min_max_load;
    logic                m_overflowed;

    partition_checker board = new();

    int     tx_gap_max   = 0;
    int     rx_stall_max = 0;
    bit     hold_request = 0;
    int     items_sent   = 0;
    longint cycle_count  = 0;

    min_max_contiguous_partition_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_group_limit (cfg_group_limit),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_weight        (s_weight),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_min_max_load  (m_min_max_load),
        .m_overflowed    (m_overflowed)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                board.set_limit(cfg_group_limit);
            if (s_valid && s_ready)
                board.note_weight(s_weight, s_last);
            if (m_valid && m_ready)
                board.check_load(m_min_max_load, m_overflowed);
        end
    end

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return WEIGHT_W'($urandom_range(0, 15));
            4, 5:    return WEIGHT_W'($urandom_range(0, 1023));
            default: return WEIGHT_W'($urandom());
        endcase
    endfunction

    task automatic send_item(input logic [WEIGHT_W-1:0] weight, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_weight <= weight;
        s_last   <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_set(input int len, input bit all_max);
        for (int i = 0; i < len; i++)
            send_item(all_max ? '1 : pick_weight(), i == len - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        cfg_valid       <= 1'b1;
        cfg_group_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall per transaction, one long hold on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int                 phase;
        int                 set_len;
        int                 phase_end;
        int                 random_start;
        logic [LIMIT_W-1:0] limit;

        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_group_limit = '0;
        s_valid         = 1'b0;
        s_weight        = '0;
        s_last          = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit of one group
        send_item(16'h0000, 1'b1);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h5555, 1'b0); send_item(16'hAAAA, 1'b0);
        send_item(16'hFFFF, 1'b0); send_item(16'h0001, 1'b1);

        write_limit(9'd256);
        send_item(16'hFFFF, 1'b0); send_item(16'hFFFF, 1'b0); send_item(16'hFFFF, 1'b1);
        send_item(16'd1, 1'b0); send_item(16'd2, 1'b0); send_item(16'd3, 1'b0);
        send_item(16'd4, 1'b0); send_item(16'd5, 1'b1);

        // zero limit behaves as a single group
        write_limit(9'd0);
        send_item(16'd10, 1'b0); send_item(16'd20, 1'b0); send_item(16'd30, 1'b1);

        write_limit(9'd2);
        send_item(16'd7, 1'b0); send_item(16'd0, 1'b0);
        send_item(16'd9, 1'b0); send_item(16'd3, 1'b1);
        send_item(16'd0, 1'b0); send_item(16'd0, 1'b1);

        write_limit(9'h1FF);
        send_item(16'd100, 1'b0); send_item(16'd200, 1'b0); send_item(16'd300, 1'b1);

        // full store, largest total, then drop past the store depth
        tx_gap_max   = 10;
        rx_stall_max = 10;
        write_limit(9'd1);
        send_set(MAX_ITEMS, 1'b1);
        write_limit(9'd3);
        send_set(MAX_ITEMS + 4, 1'b0);
        send_set(3, 1'b0);

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case (phase % 6)
                0:       limit = 9'd1;
                1:       limit = 9'd256;
                2:       limit = LIMIT_W'($urandom_range(2, 8));
                3:       limit = 9'h1FF;
                4:       limit = 9'd0;
                default: limit = LIMIT_W'($urandom_range(1, 256));
            endcase
            write_limit(limit);
            tx_gap_max   = (phase % 3 == 1) ? 0 : 10;
            rx_stall_max = (phase % 4 == 2) ? 0 : 10;
            if (phase == 2) begin
                tx_gap_max   = 0;
                hold_request = 1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
                send_set(set_len, 1'b0);
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        board.report_leftover();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmcp_pkg.sv
rtl/mmcp_ram.sv
rtl/min_max_contiguous_partition_unit.sv
verif/tb_top.sv
